### rtl/cdd_pkg.sv
// shared types, constants and lookup functions for the civil date day arithmetic block
// no dependencies; imported by cdd_to_days, cdd_from_days and the top level
package cdd_pkg;

    // field widths
    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFFSET_W = 21;
    localparam int EPOCH_W  = 25;
    localparam int WDAY_W   = 3;

    // calendar constants
    localparam int DAYS_PER_ERA = 146097;
    localparam int YEARS_PER_ERA = 400;
    localparam int EPOCH_SHIFT  = 719468;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

    // input years are biased by whole eras so the era divide works on unsigned values
    localparam int ERA_BIAS_IN = 82;
    localparam logic [16:0] YEAR_BIAS = 17'(ERA_BIAS_IN * YEARS_PER_ERA);
    localparam int DAYS_BIAS = EPOCH_SHIFT + ERA_BIAS_IN * DAYS_PER_ERA;

    // shifted day counts are biased by whole eras for the same reason
    localparam int ERA_BIAS_OUT = 100;
    localparam int TOTAL_BIAS = EPOCH_SHIFT + ERA_BIAS_OUT * DAYS_PER_ERA;

    // weekday: (days + 4) mod 7, biased by a multiple of 7 to stay non-negative
    localparam int WDAY_BIAS = 7 * (2 ** 21) + 4;

    // reciprocals for exact floor division: x / d == (x * ceil(2^k / d)) >> k
    localparam int K400 = 26;
    localparam logic [17:0] RCP400 = 18'(((64'd1 << K400) + 64'd399) / 64'd400);
    localparam int KERA = 43;
    localparam logic [25:0] RCPERA = 26'(((64'd1 << KERA) + 64'd146096) / 64'd146097);
    localparam int K1460 = 29;
    localparam logic [18:0] RCP1460 = 19'(((64'd1 << K1460) + 64'd1459) / 64'd1460);
    localparam int K365 = 27;
    localparam logic [18:0] RCP365 = 19'(((64'd1 << K365) + 64'd364) / 64'd365);

    // date to day count stage output
    typedef struct packed {
        logic                       date_valid;
        logic signed [EPOCH_W-1:0]  epoch_day;
        logic signed [OFFSET_W-1:0] day_offset;
    } cdd_days_t;

    // one full result
    typedef struct packed {
        logic                      date_valid;
        logic signed [EPOCH_W-1:0] epoch_day;
        logic [WDAY_W-1:0]         week_day;
        logic signed [YEAR_W-1:0]  out_year;
        logic [MONTH_W-1:0]        out_month;
        logic [DAY_W-1:0]          out_day;
        logic                      year_overflow;
    } cdd_result_t;

    // first day of year for months counted from march (index 12 is one past february)
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] s;
        unique case (idx)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            4'd12:   s = 9'd367;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // month length in a common year, zero for month numbers that mean nothing
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] l;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    l = 5'd30;
            4'd2:                                       l = 5'd28;
            default:                                    l = 5'd0;
        endcase
        return l;
    endfunction

    // whole centuries in a year of era (0..399)
    function automatic logic [1:0] century(input logic [8:0] yoe);
        logic [1:0] c;
        priority if (yoe >= 9'd300) c = 2'd3;
        else if (yoe >= 9'd200)     c = 2'd2;
        else if (yoe >= 9'd100)     c = 2'd1;
        else                        c = 2'd0;
        return c;
    endfunction

    // remainder by 7 of a value up to 14
    function automatic logic [2:0] mod7_small(input logic [3:0] v);
        logic [3:0] r;
        priority if (v >= 4'd14) r = 4'd0;
        else if (v >= 4'd7)      r = v - 4'd7;
        else                     r = v;
        return r[2:0];
    endfunction

endpackage

### rtl/cdd_to_days.sv
// date to day count pipeline: era split, year of era, day of era, epoch day, date check
// depends on cdd_pkg
module cdd_to_days
    import cdd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [YEAR_W-1:0]   in_year,
    input  logic [MONTH_W-1:0]         in_month,
    input  logic [DAY_W-1:0]           in_day,
    input  logic signed [OFFSET_W-1:0] day_offset,
    output logic                       out_valid,
    input  logic                       out_ready,
    output cdd_days_t                  out_days
);

    localparam int NSTG = 5;

    logic [NSTG-1:0] vld_reg, vld_next, en;

    // stage advance: a stage loads when empty or when the next one loads
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next = (en & {vld_reg[NSTG-2:0], in_valid}) | (~en & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    // stage a: march-based year and month, day of year, month checks
    logic               m_le2;
    logic signed [16:0] year_adj;
    logic [16:0]        ubias_a;
    logic [3:0]         midx_a;
    logic [9:0]         doy_a;

    always_comb
    begin
        m_le2    = (in_month <= MONTH_FEB);
        year_adj = {in_year[YEAR_W-1], in_year} - {16'd0, m_le2};
        ubias_a  = 17'(year_adj) + YEAR_BIAS;
        midx_a   = m_le2 ? (in_month + 4'd9) : (in_month - 4'd3);
        doy_a    = {1'b0, month_start(midx_a)} + {5'd0, in_day} - 10'd1;
    end

    logic [16:0]               a_ubias_reg;
    logic [9:0]                a_doy_reg;
    logic [DAY_W-1:0]          a_day_reg;
    logic [4:0]                a_len_reg;
    logic                      a_feb_reg;
    logic                      a_ok_reg;
    logic signed [OFFSET_W-1:0] a_off_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_ubias_reg <= ubias_a;
            a_doy_reg   <= doy_a;
            a_day_reg   <= in_day;
            a_len_reg   <= month_len(in_month);
            a_feb_reg   <= (in_month == MONTH_FEB);
            a_ok_reg    <= (in_month >= 4'd1) && (in_month <= 4'd12) && (in_day != '0);
            a_off_reg   <= day_offset;
        end
    end

    // stage b: era index by reciprocal multiply
    logic [34:0] prod_b;

    assign prod_b = 35'(a_ubias_reg) * 35'(RCP400);

    logic [7:0]                b_q_reg;
    logic [16:0]               b_ubias_reg;
    logic [9:0]                b_doy_reg;
    logic [DAY_W-1:0]          b_day_reg;
    logic [4:0]                b_len_reg;
    logic                      b_feb_reg;
    logic                      b_ok_reg;
    logic signed [OFFSET_W-1:0] b_off_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_q_reg     <= prod_b[K400+7:K400];
            b_ubias_reg <= a_ubias_reg;
            b_doy_reg   <= a_doy_reg;
            b_day_reg   <= a_day_reg;
            b_len_reg   <= a_len_reg;
            b_feb_reg   <= a_feb_reg;
            b_ok_reg    <= a_ok_reg;
            b_off_reg   <= a_off_reg;
        end
    end

    // stage c: year of era
    logic [16:0] yoe_full_c;

    assign yoe_full_c = b_ubias_reg - 17'(b_q_reg) * 17'(YEARS_PER_ERA);

    logic [7:0]                c_q_reg;
    logic [8:0]                c_yoe_reg;
    logic [9:0]                c_doy_reg;
    logic [DAY_W-1:0]          c_day_reg;
    logic [4:0]                c_len_reg;
    logic                      c_feb_reg;
    logic                      c_ok_reg;
    logic signed [OFFSET_W-1:0] c_off_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c_q_reg   <= b_q_reg;
            c_yoe_reg <= yoe_full_c[8:0];
            c_doy_reg <= b_doy_reg;
            c_day_reg <= b_day_reg;
            c_len_reg <= b_len_reg;
            c_feb_reg <= b_feb_reg;
            c_ok_reg  <= b_ok_reg;
            c_off_reg <= b_off_reg;
        end
    end

    // stage d: day of era, leap year and day-in-month check
    logic [18:0] doe_d;
    logic [8:0]  yr_d;
    logic        leap_d;
    logic [4:0]  lim_d;
    logic        valid_d;

    always_comb
    begin
        doe_d   = 19'(c_yoe_reg) * 19'd365 + 19'(c_yoe_reg[8:2]) - 19'(century(c_yoe_reg))
                  + {{9{c_doy_reg[9]}}, c_doy_reg};
        // year of era of the unshifted year, only meaningful for february
        yr_d    = c_yoe_reg + 9'd1;
        leap_d  = (yr_d[1:0] == 2'd0) && (yr_d != 9'd100) && (yr_d != 9'd200)
                  && (yr_d != 9'd300);
        lim_d   = (c_feb_reg && leap_d) ? 5'd29 : c_len_reg;
        valid_d = c_ok_reg && (c_day_reg <= lim_d);
    end

    logic [7:0]                d_q_reg;
    logic [18:0]               d_doe_reg;
    logic                      d_valid_reg;
    logic signed [OFFSET_W-1:0] d_off_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            d_q_reg     <= c_q_reg;
            d_doe_reg   <= doe_d;
            d_valid_reg <= valid_d;
            d_off_reg   <= c_off_reg;
        end
    end

    // stage e: days since 1970-01-01
    logic [EPOCH_W-1:0] days_e;

    assign days_e = 25'(d_q_reg) * 25'(DAYS_PER_ERA) + {{6{d_doe_reg[18]}}, d_doe_reg}
                    - 25'(DAYS_BIAS);

    cdd_days_t e_days_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            e_days_reg.date_valid <= d_valid_reg;
            e_days_reg.epoch_day  <= days_e;
            e_days_reg.day_offset <= d_off_reg;
        end
    end

    assign out_days = e_days_reg;

endmodule

### rtl/cdd_from_days.sv
// day count to date pipeline: offset add, weekday, era split, year and day of year, output register
// depends on cdd_pkg
module cdd_from_days
    import cdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cdd_days_t   in_days,
    output logic        out_valid,
    input  logic        out_ready,
    output cdd_result_t out_res
);

    localparam int NSTG = 8;

    logic [NSTG-1:0] vld_reg, vld_next, en;

    // stage advance: a stage loads when empty or when the next one loads
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next = (en & {vld_reg[NSTG-2:0], in_valid}) | (~en & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    // stage 1: biased shifted day count, octal digit sum for the weekday
    logic [EPOCH_W-1:0] t_1;
    logic [EPOCH_W-1:0] wx_1;
    logic [5:0]         wsum_1;

    always_comb
    begin
        t_1    = in_days.epoch_day
                 + {{(EPOCH_W-OFFSET_W){in_days.day_offset[OFFSET_W-1]}}, in_days.day_offset}
                 + 25'(TOTAL_BIAS);
        wx_1   = in_days.epoch_day + 25'(WDAY_BIAS);
        wsum_1 = 6'(wx_1[EPOCH_W-1]);
        for (int i = 0; i < 8; i++)
        begin
            wsum_1 = wsum_1 + 6'(wx_1[3*i +: 3]);
        end
    end

    logic [EPOCH_W-1:0]        s1_t_reg;
    logic [5:0]                s1_wsum_reg;
    logic signed [EPOCH_W-1:0] s1_days_reg;
    logic                      s1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_t_reg     <= t_1;
            s1_wsum_reg  <= wsum_1;
            s1_days_reg  <= in_days.epoch_day;
            s1_valid_reg <= in_days.date_valid;
        end
    end

    // stage 2: era index by reciprocal multiply, weekday remainder
    logic [50:0] prod_2;

    assign prod_2 = 51'(s1_t_reg) * 51'(RCPERA);

    logic [7:0]                s2_q_reg;
    logic [EPOCH_W-1:0]        s2_t_reg;
    logic [WDAY_W-1:0]         s2_wd_reg;
    logic signed [EPOCH_W-1:0] s2_days_reg;
    logic                      s2_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_q_reg     <= prod_2[KERA+7:KERA];
            s2_t_reg     <= s1_t_reg;
            s2_wd_reg    <= mod7_small(4'(s1_wsum_reg[2:0]) + 4'(s1_wsum_reg[5:3]));
            s2_days_reg  <= s1_days_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage 3: day of era and the era's first year
    logic [EPOCH_W-1:0] doe_full_3;
    logic [17:0]        ybase_3;

    always_comb
    begin
        doe_full_3 = s2_t_reg - 25'(s2_q_reg) * 25'(DAYS_PER_ERA);
        ybase_3    = (18'(s2_q_reg) - 18'(ERA_BIAS_OUT)) * 18'(YEARS_PER_ERA);
    end

    logic [17:0]               s3_doe_reg;
    logic [17:0]               s3_ybase_reg;
    logic [WDAY_W-1:0]         s3_wd_reg;
    logic signed [EPOCH_W-1:0] s3_days_reg;
    logic                      s3_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_doe_reg   <= doe_full_3[17:0];
            s3_ybase_reg <= ybase_3;
            s3_wd_reg    <= s2_wd_reg;
            s3_days_reg  <= s2_days_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 4: leap-day corrections of the day of era
    logic [36:0] prod_4;
    logic [2:0]  cent_4;

    always_comb
    begin
        prod_4 = 37'(s3_doe_reg) * 37'(RCP1460);
        cent_4 = 3'(s3_doe_reg >= 18'd36524) + 3'(s3_doe_reg >= 18'd73048)
                 + 3'(s3_doe_reg >= 18'd109572) + 3'(s3_doe_reg >= 18'd146096);
    end

    logic [6:0]                s4_quad_reg;
    logic [2:0]                s4_cent_reg;
    logic                      s4_last_reg;
    logic [17:0]               s4_doe_reg;
    logic [17:0]               s4_ybase_reg;
    logic [WDAY_W-1:0]         s4_wd_reg;
    logic signed [EPOCH_W-1:0] s4_days_reg;
    logic                      s4_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_quad_reg  <= prod_4[K1460+6:K1460];
            s4_cent_reg  <= cent_4;
            s4_last_reg  <= (s3_doe_reg == 18'd146096);
            s4_doe_reg   <= s3_doe_reg;
            s4_ybase_reg <= s3_ybase_reg;
            s4_wd_reg    <= s3_wd_reg;
            s4_days_reg  <= s3_days_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 5: day count with leap days taken out
    logic [17:0] n_5;

    assign n_5 = s4_doe_reg - 18'(s4_quad_reg) + 18'(s4_cent_reg) - 18'(s4_last_reg);

    logic [17:0]               s5_n_reg;
    logic [17:0]               s5_doe_reg;
    logic [17:0]               s5_ybase_reg;
    logic [WDAY_W-1:0]         s5_wd_reg;
    logic signed [EPOCH_W-1:0] s5_days_reg;
    logic                      s5_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_n_reg     <= n_5;
            s5_doe_reg   <= s4_doe_reg;
            s5_ybase_reg <= s4_ybase_reg;
            s5_wd_reg    <= s4_wd_reg;
            s5_days_reg  <= s4_days_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // stage 6: year of era by reciprocal multiply
    logic [36:0] prod_6;

    assign prod_6 = 37'(s5_n_reg) * 37'(RCP365);

    logic [8:0]                s6_yoe_reg;
    logic [17:0]               s6_doe_reg;
    logic [17:0]               s6_ybase_reg;
    logic [WDAY_W-1:0]         s6_wd_reg;
    logic signed [EPOCH_W-1:0] s6_days_reg;
    logic                      s6_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_yoe_reg   <= prod_6[K365+8:K365];
            s6_doe_reg   <= s5_doe_reg;
            s6_ybase_reg <= s5_ybase_reg;
            s6_wd_reg    <= s5_wd_reg;
            s6_days_reg  <= s5_days_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // stage 7: day of the march-based year
    logic [17:0] doy_full_7;

    assign doy_full_7 = s6_doe_reg - (18'(s6_yoe_reg) * 18'd365 + 18'(s6_yoe_reg[8:2])
                        - 18'(century(s6_yoe_reg)));

    logic [8:0]                s7_doy_reg;
    logic [8:0]                s7_yoe_reg;
    logic [17:0]               s7_ybase_reg;
    logic [WDAY_W-1:0]         s7_wd_reg;
    logic signed [EPOCH_W-1:0] s7_days_reg;
    logic                      s7_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_doy_reg   <= doy_full_7[8:0];
            s7_yoe_reg   <= s6_yoe_reg;
            s7_ybase_reg <= s6_ybase_reg;
            s7_wd_reg    <= s6_wd_reg;
            s7_days_reg  <= s6_days_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    // stage 8: month and day from month starts, calendar year, overflow
    logic [3:0]  mp_8;
    logic        wrap_8;
    logic [8:0]  od_8;
    logic [3:0]  om_8;
    logic [17:0] oy_8;

    always_comb
    begin
        mp_8 = '0;
        for (int i = 1; i < 12; i++)
        begin
            mp_8 = mp_8 + 4'(s7_doy_reg >= month_start(4'(i)));
        end
        wrap_8 = (mp_8 >= 4'd10);
        od_8   = s7_doy_reg - month_start(mp_8) + 9'd1;
        om_8   = wrap_8 ? (mp_8 - 4'd9) : (mp_8 + 4'd3);
        oy_8   = s7_ybase_reg + 18'(s7_yoe_reg) + 18'(wrap_8);
    end

    cdd_result_t res_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            res_reg.date_valid    <= s7_valid_reg;
            res_reg.epoch_day     <= s7_days_reg;
            res_reg.week_day      <= s7_wd_reg;
            res_reg.out_year      <= oy_8[YEAR_W-1:0];
            res_reg.out_month     <= om_8;
            res_reg.out_day       <= od_8[DAY_W-1:0];
            res_reg.year_overflow <= (oy_8[17:15] != 3'b000) && (oy_8[17:15] != 3'b111);
        end
    end

    assign out_res = res_reg;

endmodule

### rtl/civil_date_day_arithmetic_top.sv
// top level of the civil date day arithmetic block: stream ports, field packing, checks
// depends on cdd_pkg, cdd_to_days and cdd_from_days
//
// usage
//   s_* channel carries one request: a proleptic gregorian date and a signed
//   day offset. m_* channel returns one result per request, in order: the
//   date check, days since 1970-01-01, weekday (sunday = 0), and the date
//   that lies offset days later, with a flag when that year leaves 16 bits.
//   invalid dates are still converted through the same formulas.
//   a request passes 13 register stages before m_tvalid rises, the last
//   one being the output register.
//   throughput: one request per cycle while m_tready is high; the era and
//   year splits are reciprocal multiplies, so the pipeline takes a new
//   request every clock as long as the output does not stall.
//   reset clears all stage valid bits; the pipeline comes up empty and ready.
//   when m_tready is low the result holds in the output register and empty
//   stages further up keep filling; s_tready drops only once every stage
//   holds a request.
module civil_date_day_arithmetic_top
    import cdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // in_year[15:0], in_month[19:16], in_day[24:20],
                                  // day_offset[45:25], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // epoch_day[24:0], week_day[27:25], out_year[43:28],
                                  // out_month[47:44], out_day[52:48], zero fill
    output logic [1:0]  m_tuser   // date_valid[0], year_overflow[1]
);

    logic        mid_valid;
    logic        mid_ready;
    cdd_days_t   mid_days;
    cdd_result_t res;

    // date to day count
    cdd_to_days u_to_days (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_year    (s_tdata[15:0]),
        .in_month   (s_tdata[19:16]),
        .in_day     (s_tdata[24:20]),
        .day_offset (s_tdata[45:25]),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .out_days   (mid_days)
    );

    // day count plus offset back to a date
    cdd_from_days u_from_days (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_days   (mid_days),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // result packing
    assign m_tdata = {3'd0, res.out_day, res.out_month, res.out_year, res.week_day,
                      res.epoch_day};
    assign m_tuser = {res.year_overflow, res.date_valid};

    // checks
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.out_month >= 4'd1) && (res.out_month <= 4'd12))
        else $error("shifted month out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.out_day >= 5'd1) && (res.out_day <= 5'd31))
        else $error("shifted day out of range");

    a_wday_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.week_day <= 3'd6))
        else $error("weekday out of range");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready && mid_valid)
        else $error("input stalled while pipeline has room");

endmodule

### test/civil_date_day_arithmetic_top_test.sv
// testbench for civil_date_day_arithmetic_top: directed date corners, then random requests
// with bursty input and a stalling output; results are checked against a local predictor
// depends on cdd_pkg and the rtl of civil_date_day_arithmetic_top
`timescale 1ns / 100ps

module civil_date_day_arithmetic_top_test;
    import cdd_pkg::*;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;  // in_year[15:0], in_month[19:16], in_day[24:20],
                                 // day_offset[45:25], zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // epoch_day[24:0], week_day[27:25], out_year[43:28],
                                 // out_month[47:44], out_day[52:48], zero fill
    logic [1:0]  m_tuser;        // date_valid[0], year_overflow[1]

    // results still owed by the block, oldest first
    cdd_result_t expected_dates[$];

    int requests_sent   = 0;
    int results_checked = 0;
    int invalid_seen    = 0;
    int overflow_seen   = 0;
    int error_count     = 0;
    int burst_left      = 0;

    // receiver stall pattern state
    int sink_mode      = 0;
    int sink_mode_left = 0;
    int sink_hold_left = 0;

    civil_date_day_arithmetic_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results still outstanding", expected_dates.size());
        $display("Test completed with failures");
        $finish;
    end

    // quotient rounded toward minus infinity
    function automatic longint floor_quotient(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic bit is_leap_year(input longint y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    // length of month 1..12 in year y
    function automatic int month_days(input longint y, input int m);
        int n;
        case (m)
            2:             n = is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    // expected result for one request
    function automatic cdd_result_t predict_date_shift(
        input logic signed [YEAR_W-1:0]   yr,
        input logic        [MONTH_W-1:0]  mon,
        input logic        [DAY_W-1:0]    dd,
        input logic signed [OFFSET_W-1:0] off
    );
        longint y, m, d, shift, era, yoe, doy, doe, days, total, oy, mp, om, od;
        cdd_result_t r;
        y     = longint'(yr);
        m     = longint'(mon);
        d     = longint'(dd);
        shift = longint'(off);

        r.date_valid = (m >= 1 && m <= 12 && d >= 1 && d <= month_days(y, int'(m)));

        // count years from march: january, february and month zero fall in the year before
        if (m <= 2)
        begin
            y = y - 1;
            m = m + 12;
        end
        era  = floor_quotient(y, YEARS_PER_ERA);
        yoe  = y - era * YEARS_PER_ERA;
        doy  = (153 * (m - 3) + 2) / 5 + d - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * DAYS_PER_ERA + doe - EPOCH_SHIFT;
        r.epoch_day = days[EPOCH_W-1:0];
        r.week_day  = WDAY_W'(((days % 7) + 7 + 4) % 7);

        // back from a day count to a civil date
        total = days + shift + EPOCH_SHIFT;
        era   = floor_quotient(total, DAYS_PER_ERA);
        doe   = total - era * DAYS_PER_ERA;
        yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        oy    = yoe + era * YEARS_PER_ERA;
        doy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp    = (5 * doy + 2) / 153;
        od    = doy - (153 * mp + 2) / 5 + 1;
        om    = mp + 3;
        if (om > 12)
        begin
            om = om - 12;
            oy = oy + 1;
        end
        r.out_year      = oy[YEAR_W-1:0];
        r.out_month     = om[MONTH_W-1:0];
        r.out_day       = od[DAY_W-1:0];
        r.year_overflow = (oy < -32768 || oy > 32767);
        return r;
    endfunction

    // offsets of mixed reach: days, years, full range, near the extremes
    function automatic logic signed [OFFSET_W-1:0] random_offset();
        logic signed [OFFSET_W-1:0] o;
        case ($urandom_range(0, 3))
            0:       o = OFFSET_W'($urandom_range(0, 800) - 400);
            1:       o = OFFSET_W'($urandom_range(0, 80000) - 40000);
            2:       o = OFFSET_W'($urandom);
            default: o = $urandom_range(0, 1)
                         ? OFFSET_W'(21'sh0FFFFF - $urandom_range(0, 2000))
                         : OFFSET_W'(21'sh100000 + $urandom_range(0, 2000));
        endcase
        return o;
    endfunction

    // send one request; bursts of random length with random gaps in between
    task automatic send_request(
        input logic signed [YEAR_W-1:0]   yr,
        input logic        [MONTH_W-1:0]  mon,
        input logic        [DAY_W-1:0]    dd,
        input logic signed [OFFSET_W-1:0] off
    );
        s_tdata  <= {2'b00, off, dd, mon, yr};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_dates.push_back(predict_date_shift(yr, mon, dd, off));
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // hold off the sender until every result is back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
    endtask

    // epoch day and weekday around the epoch and era edges
    task automatic test_epoch_and_weekday();
        send_request(16'sd1970, 4'd1, 5'd1, 21'sd0);
        send_request(16'sd1969, 4'd12, 5'd31, 21'sd1);
        send_request(16'sd1970, 4'd1, 5'd1, -21'sd1);
        send_request(16'sd2000, 4'd3, 5'd1, -21'sd1);
        send_request(16'sd2000, 4'd2, 5'd29, 21'sd1);
        send_request(16'sd1600, 4'd1, 5'd1, 21'sd0);
        send_request(16'sd0, 4'd3, 5'd1, -21'sd1);
    endtask

    // leap february and month ends
    task automatic test_validity();
        send_request(16'sd2000, 4'd2, 5'd29, 21'sd0);
        send_request(16'sd1900, 4'd2, 5'd29, 21'sd0);
        send_request(16'sd2024, 4'd2, 5'd29, 21'sd365);
        send_request(16'sd2023, 4'd2, 5'd29, 21'sd0);
        send_request(-16'sd400, 4'd2, 5'd29, 21'sd0);
        send_request(-16'sd100, 4'd2, 5'd29, 21'sd0);
        send_request(16'sd2023, 4'd4, 5'd31, 21'sd0);
        send_request(16'sd2023, 4'd12, 5'd31, 21'sd0);
        send_request(16'sd2023, 4'd3, 5'd0, 21'sd0);
    endtask

    // month numbers outside 1..12 still go through the arithmetic
    task automatic test_odd_months();
        send_request(16'sd2021, 4'd0, 5'd15, 21'sd0);
        send_request(16'sd2021, 4'd13, 5'd1, 21'sd10);
        send_request(16'sd2021, 4'd14, 5'd31, -21'sd10);
        send_request(16'sd2021, 4'd15, 5'd31, 21'sd0);
        send_request(16'sd2021, 4'd0, 5'd0, 21'sd0);
    endtask

    // shifted year leaving the 16-bit range at either end
    task automatic test_year_overflow();
        send_request(16'sd32767, 4'd12, 5'd31, 21'sd1);
        send_request(-16'sd32768, 4'd1, 5'd1, -21'sd1);
        send_request(16'sd32767, 4'd12, 5'd31, 21'sh0FFFFF);
        send_request(-16'sd32768, 4'd1, 5'd1, 21'sh100000);
        send_request(-16'sd32768, 4'd15, 5'd31, 21'sh0FFFFF);
        send_request(16'sd32767, 4'd0, 5'd0, 21'sh100000);
        send_request(16'sd32767, 4'd1, 5'd1, -21'sd1);
    endtask

    // well-formed dates with random years and offsets
    task automatic test_random_valid_dates(input int count);
        logic signed [YEAR_W-1:0] yr;
        logic [MONTH_W-1:0]       mon;
        logic [DAY_W-1:0]         dd;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0:       yr = YEAR_W'($urandom_range(0, 800) + 1600);
                1:       yr = YEAR_W'($urandom);
                2:       yr = YEAR_W'($urandom_range(0, 2000) - 1000);
                default: yr = $urandom_range(0, 1)
                              ? YEAR_W'(16'sh7FFF - $urandom_range(0, 40))
                              : YEAR_W'(16'sh8000 + $urandom_range(0, 40));
            endcase
            mon = MONTH_W'($urandom_range(1, 12));
            dd  = DAY_W'($urandom_range(1, month_days(yr, int'(mon))));
            send_request(yr, mon, dd, random_offset());
        end
    endtask

    // every field filled with random bits
    task automatic test_random_fields(input int count);
        logic signed [YEAR_W-1:0]   yr;
        logic [MONTH_W-1:0]         mon;
        logic [DAY_W-1:0]           dd;
        logic signed [OFFSET_W-1:0] off;
        for (int i = 0; i < count; i++)
        begin
            {off, dd, mon, yr} = 46'({$urandom, $urandom});
            send_request(yr, mon, dd, off);
        end
    endtask

    // years near both ends of the range, any month and day
    task automatic test_year_edges(input int count);
        logic signed [YEAR_W-1:0] yr;
        for (int i = 0; i < count; i++)
        begin
            yr = $urandom_range(0, 1) ? YEAR_W'(16'sh7FFF - $urandom_range(0, 60))
                                      : YEAR_W'(16'sh8000 + $urandom_range(0, 60));
            send_request(yr, MONTH_W'($urandom_range(0, 15)), DAY_W'($urandom_range(0, 31)),
                         random_offset());
        end
    endtask

    // receiver: always ready, random, or ready with occasional long stalls
    always @(posedge clk)
    begin
        if (sink_mode_left == 0)
        begin
            sink_mode      <= $urandom_range(0, 2);
            sink_mode_left <= $urandom_range(50, 300);
        end
        else
            sink_mode_left <= sink_mode_left - 1;

        if (sink_mode == 0)
            m_tready <= 1'b1;
        else if (sink_mode == 1)
            m_tready <= 1'($urandom_range(0, 1));
        else if (sink_hold_left != 0)
        begin
            sink_hold_left <= sink_hold_left - 1;
            m_tready       <= 1'b0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            sink_hold_left <= $urandom_range(5, 30);
            m_tready       <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // compare each returned result with the oldest expected one
    always @(posedge clk)
    begin : check_results
        cdd_result_t got;
        cdd_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.date_valid    = m_tuser[0];
            got.epoch_day     = m_tdata[24:0];
            got.week_day      = m_tdata[27:25];
            got.out_year      = m_tdata[43:28];
            got.out_month     = m_tdata[47:44];
            got.out_day       = m_tdata[52:48];
            got.year_overflow = m_tuser[1];
            if (expected_dates.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result with no request outstanding", $realtime);
            end
            else
            begin
                want = expected_dates.pop_front();
                results_checked++;
                if (!want.date_valid)
                    invalid_seen++;
                if (want.year_overflow)
                    overflow_seen++;
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("%0t: mismatch on result %0d", $realtime, results_checked);
                        $display("  expected valid=%0d epoch=%0d wday=%0d date=%0d-%0d-%0d ovf=%0d",
                                 want.date_valid, want.epoch_day, want.week_day, want.out_year,
                                 want.out_month, want.out_day, want.year_overflow);
                        $display("  actual   valid=%0d epoch=%0d wday=%0d date=%0d-%0d-%0d ovf=%0d",
                                 got.date_valid, got.epoch_day, got.week_day, got.out_year,
                                 got.out_month, got.out_day, got.year_overflow);
                    end
                end
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_epoch_and_weekday();
        test_validity();
        test_odd_months();
        test_year_overflow();
        wait_all_results();

        test_random_valid_dates(1100);
        wait_all_results();
        test_random_fields(450);
        test_year_edges(250);
        wait_all_results();

        // pipeline is 13 stages deep; allow a margin for stray results
        repeat (40) @(posedge clk);
        if (expected_dates.size() != 0)
            error_count += expected_dates.size();

        $display("sent %0d date requests, checked %0d results", requests_sent, results_checked);
        $display("results with invalid input date: %0d, with year overflow: %0d",
                 invalid_seen, overflow_seen);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### civil_date_day_arithmetic_top.f
rtl/cdd_pkg.sv
rtl/cdd_to_days.sv
rtl/cdd_from_days.sv
rtl/civil_date_day_arithmetic_top.sv
test/civil_date_day_arithmetic_top_test.sv
